### rtl/pssm_pkg.sv
`default_nettype none

package pssm_pkg;

    // Default sizes of the score table.
    localparam int DEF_MAX_WINDOW = 32;
    localparam int DEF_ALPHABET   = 32;

    // Fixed field widths.
    localparam int SCORE_W = 32;
    localparam int RES_W   = 5;
    localparam int ROW_W   = 6;
    localparam int LEN_W   = 6;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Request type codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_SCAN = 1'b1;

    // One classified beat as it travels from the front to the back.
    typedef struct packed {
        logic                      is_load;
        logic                      write;
        logic                      bad_row;
        logic                      start;
        logic                      res_ok;
        logic [ROW_W-1:0]          row_idx;
        logic [RES_W-1:0]          residue;
        logic signed [SCORE_W-1:0] data;
    } qitem_t;

endpackage

`default_nettype wire

### rtl/pssm_ram.sv
`default_nettype none

module pssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/pssm_queue.sv
`default_nettype none

module pssm_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire pssm_pkg::qitem_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output pssm_pkg::qitem_t     head,
    output logic                 empty
);

    import pssm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qitem_t           entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

endmodule

`default_nettype wire

### rtl/pssm_front.sv
`default_nettype none

module pssm_front #(
    parameter int MAX_WINDOW = pssm_pkg::DEF_MAX_WINDOW,
    parameter int ALPHABET   = pssm_pkg::DEF_ALPHABET
) (
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_req_type,
    input  wire logic [pssm_pkg::RES_W-1:0]           s_residue,
    input  wire logic [pssm_pkg::ROW_W-1:0]           s_row,
    input  wire logic signed [pssm_pkg::SCORE_W-1:0]  s_entry_score,
    input  wire logic                                 s_seq_start,
    input  wire logic [$clog2(MAX_WINDOW + 1)-1:0]    win_len,
    input  wire logic                                 clearing,
    input  wire logic                                 q_full,
    output logic                                      q_push,
    output pssm_pkg::qitem_t                          q_item
);

    import pssm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Lowest storable entry for each window length, so that a full window of
    // such entries cannot saturate at the bottom.
    logic signed [SCORE_W-1:0] floor_tab [MAX_WINDOW];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_floor
        localparam longint FloorVal = (-64'sd2147483648) / longint'(g + 1) + 64'sd1;
        assign floor_tab[g] = SCORE_W'(FloorVal);
    end

    logic                      is_load;
    logic                      row_bad;
    logic                      res_ok;
    logic [IDX_W-1:0]          len_idx;
    logic signed [SCORE_W-1:0] floor_sel;
    logic signed [SCORE_W-1:0] clamped;

    always_comb begin
        is_load   = (s_req_type == REQ_LOAD);
        row_bad   = (s_row == '0) || (8'(s_row) > 8'(win_len));
        res_ok    = (8'(s_residue) < 8'(ALPHABET));
        len_idx   = IDX_W'(win_len - CNT_W'(1));
        floor_sel = floor_tab[len_idx];
        clamped   = (s_entry_score < floor_sel) ? floor_sel : s_entry_score;

        q_item.is_load = is_load;
        q_item.write   = is_load && !row_bad && res_ok;
        q_item.bad_row = is_load && row_bad;
        q_item.start   = !is_load && s_seq_start;
        q_item.res_ok  = res_ok;
        q_item.row_idx = s_row - ROW_W'(1);
        q_item.residue = s_residue;
        q_item.data    = clamped;
    end

    assign s_ready = !q_full && !clearing;
    assign q_push  = s_valid && s_ready;

endmodule

`default_nettype wire

### rtl/pssm_back.sv
`default_nettype none

module pssm_back #(
    parameter int MAX_WINDOW = pssm_pkg::DEF_MAX_WINDOW,
    parameter int ALPHABET   = pssm_pkg::DEF_ALPHABET
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [$clog2(MAX_WINDOW + 1)-1:0]   win_len,
    output logic                                     clearing,
    input  wire logic                                q_empty,
    input  wire pssm_pkg::qitem_t                    q_head,
    output logic                                     q_pop,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [pssm_pkg::SCORE_W-1:0]      m_window_score,
    output logic                                     m_window_full,
    output logic                                     m_bad_row
);

    import pssm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AW    = $clog2(ALPHABET);

    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0]   s;
        logic signed [SCORE_W-1:0] r;
        s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            r = s[SCORE_W] ? {1'b1, {(SCORE_W - 1){1'b0}}} : {1'b0, {(SCORE_W - 1){1'b1}}};
        end else begin
            r = s[SCORE_W-1:0];
        end
        return r;
    endfunction

    // Clearing sweep after reset.
    logic          clear_reg, clear_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // Second stage: table read data is valid here.
    logic s2_valid_reg, s2_valid_next;
    logic s2_load_reg;
    logic s2_bad_reg;
    logic s2_start_reg;
    logic s2_resok_reg;

    // Chain of cells and residue count.
    logic signed [SCORE_W-1:0] psum_reg  [MAX_WINDOW];
    logic signed [SCORE_W-1:0] psum_next [MAX_WINDOW];
    logic [CNT_W-1:0]          fill_reg, fill_next;

    logic                      m_valid_reg, m_valid_next;
    logic signed [SCORE_W-1:0] m_score_reg;
    logic                      m_full_reg;
    logic                      m_bad_reg;

    logic                      out_adv;
    logic                      s2_go;
    logic                      ram_re;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             ram_raddr;
    logic [SCORE_W-1:0]        ram_wdata;
    logic [MAX_WINDOW-1:0]     ram_we;
    logic [SCORE_W-1:0]        ram_rd   [MAX_WINDOW];
    logic signed [SCORE_W-1:0] cell_add [MAX_WINDOW];
    logic signed [SCORE_W-1:0] cell_base [MAX_WINDOW];
    logic [CNT_W-1:0]          fill_base;
    logic                      win_full;
    logic [IDX_W-1:0]          len_idx;

    assign clearing = clear_reg;
    assign out_adv  = !m_valid_reg || m_ready;
    assign s2_go    = s2_valid_reg && out_adv;
    assign q_pop    = !q_empty && !clear_reg && (!s2_valid_reg || out_adv);
    assign ram_re   = q_pop && !q_head.is_load;

    always_comb begin
        ram_raddr = AW'(q_head.residue);
        if (clear_reg) begin
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_waddr = AW'(q_head.residue);
            ram_wdata = q_head.data;
        end
    end

    for (genvar r = 0; r < MAX_WINDOW; r++) begin : g_row
        assign ram_we[r] = clear_reg ||
            (q_pop && q_head.write && (IDX_W'(q_head.row_idx) == IDX_W'(r)));

        pssm_ram #(
            .WIDTH(SCORE_W),
            .DEPTH(ALPHABET)
        ) u_ram (
            .clk  (aclk),
            .we   (ram_we[r]),
            .waddr(ram_waddr),
            .wdata(ram_wdata),
            .re   (ram_re),
            .raddr(ram_raddr),
            .rdata(ram_rd[r])
        );

        assign cell_add[r]  = s2_resok_reg ? $signed(ram_rd[r]) : '0;
        assign cell_base[r] = s2_start_reg ? '0 : psum_reg[r];
    end

    // Cell i adds row i+1 to the window that cell i-1 held one residue ago.
    always_comb begin
        psum_next[0] = cell_add[0];
        for (int i = 1; i < MAX_WINDOW; i++) begin
            psum_next[i] = sat_add(cell_base[i-1], cell_add[i]);
        end
    end

    always_comb begin
        fill_base = s2_start_reg ? '0 : fill_reg;
        if (fill_base == CNT_W'(MAX_WINDOW)) begin
            fill_next = fill_base;
        end else begin
            fill_next = fill_base + CNT_W'(1);
        end
        win_full = (fill_next >= win_len);
        len_idx  = IDX_W'(win_len - CNT_W'(1));
    end

    always_comb begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(ALPHABET - 1)) begin
                clear_next = 1'b0;
            end
        end

        if (q_pop) begin
            s2_valid_next = 1'b1;
        end else if (s2_go) begin
            s2_valid_next = 1'b0;
        end else begin
            s2_valid_next = s2_valid_reg;
        end

        m_valid_next = out_adv ? s2_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fill_reg     <= '0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                psum_reg[i] <= '0;
            end
        end else begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s2_go && !s2_load_reg) begin
                fill_reg <= fill_next;
                for (int i = 0; i < MAX_WINDOW; i++) begin
                    psum_reg[i] <= psum_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s2_load_reg  <= q_head.is_load;
            s2_bad_reg   <= q_head.bad_row;
            s2_start_reg <= q_head.start;
            s2_resok_reg <= q_head.res_ok;
        end
        if (s2_go) begin
            m_bad_reg <= s2_load_reg && s2_bad_reg;
            if (s2_load_reg) begin
                m_score_reg <= '0;
                m_full_reg  <= 1'b0;
            end else begin
                m_score_reg <= win_full ? psum_next[len_idx] : '0;
                m_full_reg  <= win_full;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_window_score = m_score_reg;
    assign m_window_full  = m_full_reg;
    assign m_bad_row      = m_bad_reg;

    a_no_issue_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> !q_pop && !s2_valid_reg)
        else $error("beat issued during the table clearing sweep");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_WINDOW))
        else $error("residue count beyond the longest window");

    a_short_window_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_full |-> m_window_score == '0)
        else $error("nonzero score on a window that is not full");

    a_load_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_row |-> !m_window_full)
        else $error("load result flagged as a full window");

endmodule

`default_nettype wire

### rtl/pssm_window_scorer.sv
`default_nettype none

// Position-specific score table scanner. Load beats (s_req_type 0) write one
// entry of a table of MAX_WINDOW rows by ALPHABET residue columns; the entry
// is clamped from below so that a full window of entries cannot underflow,
// and a load naming a row outside 1..motif_length returns m_bad_row and
// writes nothing. Scan beats (s_req_type 1) carry one sequence residue each
// and return the saturated sum of the table entries for the window of the
// last motif_length residues; m_window_full stays low, with a zero score,
// until that many residues of the current sequence have arrived, and
// s_seq_start opens a new sequence. Every input beat returns exactly one
// result beat, in order. The block takes one beat per clock cycle when the
// result side keeps up: each residue does one read of every row memory and
// one saturating add in every cell of the partial-sum chain but the first, so
// the pace is set by that single table read. A beat goes through the queue,
// the table read stage and the output register to the result channel. A
// two-entry queue between the classifying front and the table/cell back lets
// the input keep flowing for a while when the result side stalls. After reset
// the table is cleared by a sweep over all ALPHABET residue addresses (32 at
// the default size), during which s_ready stays low; motif_length may still
// be written then. motif_length should only be written while no beat is in
// flight; 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.

module pssm_window_scorer #(
    parameter int MAX_WINDOW = pssm_pkg::DEF_MAX_WINDOW,
    parameter int ALPHABET   = pssm_pkg::DEF_ALPHABET
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [pssm_pkg::LEN_W-1:0]          cfg_wr_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic [pssm_pkg::RES_W-1:0]          s_residue,
    input  wire logic [pssm_pkg::ROW_W-1:0]          s_row,
    input  wire logic signed [pssm_pkg::SCORE_W-1:0] s_entry_score,
    input  wire logic                                s_seq_start,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [pssm_pkg::SCORE_W-1:0]      m_window_score,
    output logic                                     m_window_full,
    output logic                                     m_bad_row
);

    import pssm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // The effective window length is held already limited to 1..MAX_WINDOW,
    // so the rest of the block never sees an out-of-range length.
    logic [CNT_W-1:0] win_len_reg, win_len_next;

    always_comb begin
        win_len_next = win_len_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                win_len_next = CNT_W'(1);
            end else if (8'(cfg_wr_data) > 8'(MAX_WINDOW)) begin
                win_len_next = CNT_W'(MAX_WINDOW);
            end else begin
                win_len_next = CNT_W'(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= CNT_W'(1);
        end else begin
            win_len_reg <= win_len_next;
        end
    end

    logic   clearing;
    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;
    qitem_t q_item;
    qitem_t q_head;

    // The front classifies each beat: load or scan, row check, entry clamp.
    pssm_front #(
        .MAX_WINDOW(MAX_WINDOW),
        .ALPHABET  (ALPHABET)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_residue    (s_residue),
        .s_row        (s_row),
        .s_entry_score(s_entry_score),
        .s_seq_start  (s_seq_start),
        .win_len      (win_len_reg),
        .clearing     (clearing),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    pssm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_item(q_item),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // The back owns the table memories and the chain of partial sums.
    pssm_back #(
        .MAX_WINDOW(MAX_WINDOW),
        .ALPHABET  (ALPHABET)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .win_len       (win_len_reg),
        .clearing      (clearing),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_window_score(m_window_score),
        .m_window_full (m_window_full),
        .m_bad_row     (m_bad_row)
    );

endmodule

`default_nettype wire

### sim/pssm_window_scorer_test.sv
`timescale 1ns / 1ps

module pssm_window_scorer_test;
    import pssm_pkg::*;

    localparam int MAX_WINDOW     = DEF_MAX_WINDOW;
    localparam int ALPHABET       = DEF_ALPHABET;
    // No beat in either direction for this many cycles means the block is stuck.
    // The longest quiet stretch in a correct run is the reset plus the table
    // clearing sweep, or one long stall on either side.
    localparam int WATCHDOG_LIMIT = 2000;
    // Mismatch lines printed before the report goes quiet; counting goes on.
    localparam int PRINT_LIMIT    = 50;

    // One input beat, field for field as it appears on the s_ ports.
    typedef struct {
        logic                      req_type;
        logic [RES_W-1:0]          residue;
        logic [ROW_W-1:0]          row;
        logic signed [SCORE_W-1:0] entry_score;
        logic                      seq_start;
    } beat_t;

    // One result beat as it appears on the m_ ports.
    typedef struct {
        logic signed [SCORE_W-1:0] window_score;
        logic                      window_full;
        logic                      bad_row;
    } window_result_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                      cfg_wr_en;
    logic [LEN_W-1:0]          cfg_wr_data;

    logic                      s_valid;
    logic                      s_ready;
    logic                      s_req_type;
    logic [RES_W-1:0]          s_residue;
    logic [ROW_W-1:0]          s_row;
    logic signed [SCORE_W-1:0] s_entry_score;
    logic                      s_seq_start;

    logic                      m_valid;
    logic                      m_ready;
    logic signed [SCORE_W-1:0] m_window_score;
    logic                      m_window_full;
    logic                      m_bad_row;

    // Our own copy of the block's state: the score table, the chain of open
    // window sums, the count of residues seen in this sequence and the
    // programmed window length.
    logic signed [SCORE_W-1:0] entry_table [MAX_WINDOW][ALPHABET];
    logic signed [SCORE_W-1:0] open_sums [MAX_WINDOW];
    int unsigned               residues_seen;
    logic [LEN_W-1:0]          window_len;

    // Results predicted for accepted beats, oldest first.
    window_result_t pending_results [$];
    int             mismatch_count = 0;

    // When set, the sender or the receiver runs without any idle cycles.
    bit tx_steady;
    bit rx_steady;
    int rx_stall_left = 0;

    pssm_window_scorer #(
        .MAX_WINDOW (MAX_WINDOW),
        .ALPHABET   (ALPHABET)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_residue      (s_residue),
        .s_row          (s_row),
        .s_entry_score  (s_entry_score),
        .s_seq_start    (s_seq_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_score (m_window_score),
        .m_window_full  (m_window_full),
        .m_bad_row      (m_bad_row)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Idle stretch length: mostly none, sometimes short, rarely long.
    function automatic int idle_span();
        int pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Score values that lean on the extremes, on small sums that never
    // saturate, and on the full 32-bit range.
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int pick = $urandom_range(0, 9);
        if (pick == 0) return 32'sh7FFF_FFFF;
        if (pick == 1) return 32'sh8000_0000;
        if (pick < 6) return int'($urandom_range(0, 2000)) - 1000;
        return $urandom;
    endfunction

    // The window length as the block uses it: 0 acts as 1 and anything past
    // the chain length acts as the full chain.
    function automatic int unsigned active_len();
        if (window_len == 0) return 1;
        if (window_len > MAX_WINDOW) return MAX_WINDOW;
        return window_len;
    endfunction

    function automatic logic signed [SCORE_W-1:0] clip_score(input longint total);
        if (total > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (total < -64'sd2147483648) return 32'sh8000_0000;
        return total[SCORE_W-1:0];
    endfunction

    // Advances our copy of the block by one beat and gives the result beat
    // that the block has to return for it.
    task automatic score_beat(input beat_t b, output window_result_t r);
        int unsigned k;
        longint      floor_v;
        longint      v;
        longint      add;
        bit          res_ok;
        k = active_len();
        res_ok = (b.residue < ALPHABET);
        r.window_score = '0;
        r.window_full = 1'b0;
        r.bad_row = 1'b0;
        if (b.req_type == REQ_LOAD) begin
            // The clamp keeps a full window of stored entries above the
            // most negative 32-bit value, for the length in force now.
            floor_v = -64'sd2147483648 / longint'(k) + 1;
            if (b.row < 1 || b.row > k) begin
                r.bad_row = 1'b1;
            end else if (res_ok) begin
                v = b.entry_score;
                if (v < floor_v) v = floor_v;
                entry_table[b.row - 1][b.residue] = v[SCORE_W-1:0];
            end
        end else begin
            if (b.seq_start) begin
                foreach (open_sums[i]) open_sums[i] = '0;
                residues_seen = 0;
            end
            // Cell i carries rows 1..i+1 of the window that opened i residues
            // ago; walking down keeps each cell reading its neighbor's old sum.
            for (int i = MAX_WINDOW - 1; i >= 1; i--) begin
                add = res_ok ? longint'(entry_table[i][b.residue]) : 64'sd0;
                open_sums[i] = clip_score(longint'(open_sums[i - 1]) + add);
            end
            open_sums[0] = res_ok ? entry_table[0][b.residue] : '0;
            if (residues_seen < MAX_WINDOW) residues_seen++;
            if (residues_seen >= k) begin
                r.window_score = open_sums[k - 1];
                r.window_full = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Presents one beat from a falling edge, holds it until the block takes
    // it, records the expected result, and then idles the input at random.
    // It returns at a falling edge without touching s_valid in that step, so
    // the next beat can follow back to back.
    task automatic send_item(input beat_t b);
        window_result_t want;
        int             gap;
        s_valid       <= 1'b1;
        s_req_type    <= b.req_type;
        s_residue     <= b.residue;
        s_row         <= b.row;
        s_entry_score <= b.entry_score;
        s_seq_start   <= b.seq_start;
        do @(posedge aclk); while (s_ready !== 1'b1);
        score_beat(b, want);
        pending_results.push_back(want);
        @(negedge aclk);
        gap = tx_steady ? 0 : idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Table write; the sequence start bit means nothing here, so it is random.
    task automatic send_load(input int row, input int residue,
                             input logic signed [SCORE_W-1:0] score);
        beat_t b;
        b.req_type    = REQ_LOAD;
        b.residue     = RES_W'(residue);
        b.row         = ROW_W'(row);
        b.entry_score = score;
        b.seq_start   = 1'($urandom_range(0, 1));
        send_item(b);
    endtask

    // Sequence residue; row and score are ignored by the block, so they are
    // random to keep those bits moving.
    task automatic send_scan(input int residue, input bit start);
        beat_t b;
        b.req_type    = REQ_SCAN;
        b.residue     = RES_W'(residue);
        b.row         = ROW_W'($urandom);
        b.entry_score = $urandom;
        b.seq_start   = start;
        send_item(b);
    endtask

    // Stops sending and waits, at falling edges, until every expected result
    // beat has come back. It always lets at least one falling edge pass.
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // The length register may only change with nothing in flight, so the
    // pipeline is drained first and then left idle to settle.
    task automatic set_motif_length(input logic [LEN_W-1:0] value);
        wait_drain();
        repeat (4) @(negedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        window_len = value;
    endtask

    // Straight out of reset: length 1, an all-zero table, rows outside 1..1
    // refused, and both score extremes stored, one of them clamped.
    task automatic test_reset_defaults();
        send_scan(0, 1'b1);
        send_load(0, 0, 32'sd5);
        send_load(2, 0, 32'sd5);
        send_load(1, 31, 32'sh7FFF_FFFF);
        send_load(1, 0, 32'sh8000_0000);
        send_scan(31, 1'b0);
        send_scan(0, 1'b0);
    endtask

    // Two-row window: a short window reports not full, two clamped negatives
    // underflow and saturate low, two maxima saturate high, and a new
    // sequence empties the window again.
    task automatic test_window_saturation();
        set_motif_length(2);
        send_load(2, 0, 32'sh8000_0000);
        send_load(2, 31, 32'sh7FFF_FFFF);
        send_load(63, 5, 32'sd7);
        send_scan(0, 1'b1);
        send_scan(0, 1'b0);
        send_scan(31, 1'b0);
        send_scan(31, 1'b0);
        send_scan(31, 1'b1);
    endtask

    // Register values past both ends of the legal range.
    task automatic test_length_extremes();
        set_motif_length(0);
        send_scan(31, 1'b1);
        send_load(2, 3, 32'sd9);
        set_motif_length(63);
        send_load(32, 1, -32'sd5);
        send_load(33, 1, -32'sd5);
    endtask

    // The length changes while a sequence is open; the open sums carry over
    // and the window is read from the cell for the new length.
    task automatic test_length_change_mid_sequence();
        set_motif_length(3);
        send_scan(1, 1'b1);
        send_scan(2, 1'b0);
        send_scan(3, 1'b0);
        set_motif_length(1);
        send_scan(31, 1'b0);
        set_motif_length(2);
        send_scan(0, 1'b0);
    endtask

    // Phases of about a hundred beats, each with its own window length and
    // idling pattern. Most beats are whole sequences opened by a start bit,
    // mixed with bursts of legal table writes, random noise beats and pauses
    // that let the result side empty out. Now and then a phase continues the
    // previous phase's sequence across the length change.
    task automatic test_random_traffic();
        beat_t b;
        int    len;
        int    k;
        int    sent;
        int    pick;
        int    seq_len;
        bit    narrow;
        bit    carry_over;
        for (int phase = 0; phase < 16; phase++) begin
            case (phase)
                0: begin
                    len = 1;
                end
                1: begin
                    len = MAX_WINDOW;
                end
                2: begin
                    len = 0;
                end
                3: begin
                    len = 63;
                end
                default: begin
                    len = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                               : $urandom_range(1, MAX_WINDOW);
                end
            endcase
            set_motif_length(len[LEN_W-1:0]);
            k = int'(active_len());
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            carry_over = (phase > 0) && ($urandom_range(0, 2) == 0);
            sent = 0;
            while (sent < 100) begin
                pick = $urandom_range(0, 99);
                narrow = 1'($urandom_range(0, 1));
                if (pick < 15) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_load($urandom_range(1, k),
                                  narrow ? $urandom_range(0, 3) : $urandom_range(0, 31),
                                  pick_score());
                        sent++;
                    end
                end else if (pick < 22) begin
                    b.req_type    = 1'($urandom_range(0, 1));
                    b.residue     = RES_W'($urandom);
                    b.row         = ROW_W'($urandom);
                    b.entry_score = pick_score();
                    b.seq_start   = 1'($urandom_range(0, 1));
                    send_item(b);
                    sent++;
                end else if (pick < 24) begin
                    wait_drain();
                end else begin
                    // A few sequences end before the window ever fills.
                    seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, k)
                                                         : $urandom_range(k, k + 12);
                    for (int j = 0; j < seq_len; j++) begin
                        send_scan(narrow ? $urandom_range(0, 3) : $urandom_range(0, 31),
                                  (j == 0) && !carry_over);
                        sent++;
                    end
                    carry_over = 1'b0;
                end
            end
        end
    endtask

    // The result side drops ready for random stretches, unless told to keep up.
    always @(negedge aclk) begin
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady) rx_stall_left <= idle_span();
        end
    end

    // Every result beat is matched against the oldest prediction.
    always @(posedge aclk) begin : check_results
        window_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no beat waiting for it");
            end else begin
                want = pending_results.pop_front();
                if (m_window_score !== want.window_score)
                    report_mismatch($sformatf("window_score %0d, expected %0d",
                                              m_window_score, want.window_score));
                if (m_window_full !== want.window_full)
                    report_mismatch($sformatf("window_full %b, expected %b",
                                              m_window_full, want.window_full));
                if (m_bad_row !== want.bad_row)
                    report_mismatch($sformatf("bad_row %b, expected %b",
                                              m_bad_row, want.bad_row));
            end
        end
    end

    // Ends the run when no beat has moved on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_req_type    = REQ_LOAD;
        s_residue     = '0;
        s_row         = '0;
        s_entry_score = '0;
        s_seq_start   = 1'b0;
        m_ready       = 1'b0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;

        // Our copy starts where the block does after reset.
        foreach (entry_table[r, c]) entry_table[r][c] = '0;
        foreach (open_sums[i]) open_sums[i] = '0;
        residues_seen = 0;
        window_len    = LEN_W'(1);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The block clears its table after reset with s_ready low; the first
        // beat simply waits for it.
        test_reset_defaults();
        test_window_saturation();
        test_length_extremes();
        test_length_change_mid_sequence();
        test_random_traffic();

        wait_drain();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
